// File: hdl/bba_pkg.sv
// bba_pkg: shared types, codes and constants of the buddy block allocator
// used by bba_ctrl, bba_datapath and buddy_block_allocator; no dependencies
package bba_pkg;

  localparam int TOP_ORDER_DEF = 19;
  localparam int MIN_ORDER_DEF = 5;
  localparam int ADDR_W        = 32;
  localparam int ORD_W         = 5;
  localparam int STAT_W        = 3;
  localparam int DATA_W        = 72;
  localparam int CFG_W         = 32;

  localparam logic [ADDR_W-1:0] BASE_RESET      = 32'h0001_0000;
  localparam logic [ORD_W-1:0]  MAX_ORDER_RESET = 5'd16;

  // configuration register indexes
  localparam logic REG_BASE      = 1'b0;
  localparam logic REG_MAX_ORDER = 1'b1;

  typedef enum logic [1:0] {
    NODE_UNUSED = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_SPLIT  = 2'd2,
    NODE_ALLOC  = 2'd3
  } node_t;

  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED     = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_RELEASED    = 3'd3,
    ST_BAD_RELEASE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    WA_IDX, WA_BUDDY, WA_LEFT, WA_RIGHT, WA_CLR
  } wsel_t;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ROOT, IDX_LEFT, IDX_UP, IDX_NEXT, IDX_REL
  } idx_op_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    rd_buddy;
    logic    wr_en;
    wsel_t   wr_sel;
    node_t   wr_val;
    idx_op_t idx_op;
    logic    res_load;
    status_t res_code;
  } cmd_t;

  typedef struct packed {
    logic  action;
    logic  too_large;
    logic  no_fit;
    logic  rel_bad;
    node_t node;
    logic  idx_root;
    logic  idx_odd;
    logic  ord_eq_tgt;
    logic  clr_last;
  } sts_t;

  // smallest k >= 1 with 2^k >= size, 32 when above 2^31
  function automatic logic [5:0] ceil_order(input logic [31:0] size);
    logic [5:0] k;
    k = 6'd32;
    for (int i = 31; i >= 1; i--) begin
      if ({1'b0, size} <= (33'd1 << i)) k = 6'(i);
    end
    return k;
  endfunction

endpackage

// File: hdl/bba_ctrl.sv
// bba_ctrl: sequencer for clearing, tree search, splitting and merging
// depends on bba_pkg; drives bba_datapath through cmd_t, reads sts_t
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISPATCH,
    S_A_RD, S_A_EVAL, S_A_CLIMB, S_SPLIT1, S_SPLIT2, S_SPLIT3, S_A_TAKE,
    S_R_RD, S_R_EVAL, S_R_MERGE, S_R_BEVAL, S_R_W1, S_R_W2, S_R_W3,
    S_FIN
  } state_t;

  state_t            state, state_next;
  bba_pkg::status_t  code, code_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.wr_sel   = bba_pkg::WA_IDX;
    cmd.wr_val   = bba_pkg::NODE_UNUSED;
    cmd.idx_op   = bba_pkg::IDX_HOLD;
    cmd.res_code = code;
    state_next   = state;
    code_next    = code;
    case (state)
      S_CLR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = bba_pkg::WA_CLR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.action) begin
          if (sts.rel_bad) begin
            code_next  = bba_pkg::ST_BAD_RELEASE;
            state_next = S_FIN;
          end else begin
            cmd.idx_op = bba_pkg::IDX_REL;
            state_next = S_R_RD;
          end
        end else if (sts.too_large) begin
          code_next  = bba_pkg::ST_TOO_LARGE;
          state_next = S_FIN;
        end else if (sts.no_fit) begin
          code_next  = bba_pkg::ST_NO_FREE;
          state_next = S_FIN;
        end else begin
          cmd.idx_op = bba_pkg::IDX_ROOT;
          state_next = S_A_RD;
        end
      end
      S_A_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_A_EVAL;
      end
      S_A_EVAL: begin
        if (sts.node == bba_pkg::NODE_FREE) begin
          state_next = S_SPLIT1;
        end else if (!sts.ord_eq_tgt && sts.node == bba_pkg::NODE_SPLIT) begin
          cmd.idx_op = bba_pkg::IDX_LEFT;
          state_next = S_A_RD;
        end else begin
          state_next = S_A_CLIMB;
        end
      end
      S_A_CLIMB: begin
        if (sts.idx_root) begin
          code_next  = bba_pkg::ST_NO_FREE;
          state_next = S_FIN;
        end else if (sts.idx_odd) begin
          cmd.idx_op = bba_pkg::IDX_UP;
        end else begin
          cmd.idx_op = bba_pkg::IDX_NEXT;
          state_next = S_A_RD;
        end
      end
      S_SPLIT1: begin
        if (sts.ord_eq_tgt) begin
          state_next = S_A_TAKE;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_val = bba_pkg::NODE_SPLIT;
          state_next = S_SPLIT2;
        end
      end
      S_SPLIT2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = bba_pkg::WA_LEFT;
        cmd.wr_val = bba_pkg::NODE_FREE;
        state_next = S_SPLIT3;
      end
      S_SPLIT3: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = bba_pkg::WA_RIGHT;
        cmd.wr_val = bba_pkg::NODE_FREE;
        cmd.idx_op = bba_pkg::IDX_LEFT;
        state_next = S_SPLIT1;
      end
      S_A_TAKE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_val = bba_pkg::NODE_ALLOC;
        code_next  = bba_pkg::ST_GRANTED;
        state_next = S_FIN;
      end
      S_R_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_R_EVAL;
      end
      S_R_EVAL: begin
        if (sts.node != bba_pkg::NODE_ALLOC) begin
          code_next  = bba_pkg::ST_BAD_RELEASE;
          state_next = S_FIN;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_val = bba_pkg::NODE_FREE;
          state_next = S_R_MERGE;
        end
      end
      S_R_MERGE: begin
        if (sts.idx_root) begin
          code_next  = bba_pkg::ST_RELEASED;
          state_next = S_FIN;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_buddy = 1'b1;
          state_next   = S_R_BEVAL;
        end
      end
      S_R_BEVAL: begin
        if (sts.node == bba_pkg::NODE_FREE) begin
          state_next = S_R_W1;
        end else begin
          code_next  = bba_pkg::ST_RELEASED;
          state_next = S_FIN;
        end
      end
      S_R_W1: begin
        cmd.wr_en  = 1'b1;
        state_next = S_R_W2;
      end
      S_R_W2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = bba_pkg::WA_BUDDY;
        cmd.idx_op = bba_pkg::IDX_UP;
        state_next = S_R_W3;
      end
      S_R_W3: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_val = bba_pkg::NODE_FREE;
        state_next = S_R_MERGE;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      code     <= bba_pkg::ST_GRANTED;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      if (cmd.res_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  a_clr_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !s_tready)
    else $error("input taken during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is at work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before transfer");

  a_write_not_during_read_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !cmd.wr_en)
    else $error("tree read and write in the same cycle");

endmodule

// File: hdl/bba_datapath.sv
// bba_datapath: node state memory, walk index, configuration, request and result registers
// depends on bba_pkg; commanded by bba_ctrl
module bba_datapath #(
  parameter int TOP_ORDER = bba_pkg::TOP_ORDER_DEF,
  parameter int MIN_ORDER = bba_pkg::MIN_ORDER_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::cmd_t                 cmd,
  output bba_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_action,
  input  logic [bba_pkg::DATA_W-1:0]    in_data,
  output logic [bba_pkg::STAT_W-1:0]    out_status,
  output logic [bba_pkg::DATA_W-1:0]    out_data
);

  localparam int IW    = TOP_ORDER - MIN_ORDER + 1;
  localparam int DEPTH = 2 ** IW;
  localparam int AW    = bba_pkg::ADDR_W;
  localparam int OW    = bba_pkg::ORD_W;

  logic [1:0]    mem [DEPTH];
  logic [1:0]    rdata;
  logic [IW-1:0] clr_cnt;
  logic [IW-1:0] idx, waddr, raddr, rel_idx;
  logic [OW-1:0] ord, tgt, rord;
  logic [5:0]    k6;
  logic          action;
  logic [AW-1:0] addr, base, offset, start_c, span_mask;
  logic [OW-1:0] max_order;
  logic [TOP_ORDER:0] pos_w;
  logic [TOP_ORDER:0] rel_w;
  logic [1:0]    wval;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= bba_pkg::BASE_RESET;
      max_order <= bba_pkg::MAX_ORDER_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        bba_pkg::REG_BASE:      base      <= cfg_data;
        bba_pkg::REG_MAX_ORDER: max_order <= cfg_data[OW-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= in_action;
      k6     <= bba_pkg::ceil_order(in_data[31:0]);
      addr   <= in_data[63:32];
      rord   <= in_data[68:64];
    end
  end

  assign tgt    = (k6 < 6'(MIN_ORDER)) ? OW'(MIN_ORDER) : k6[OW-1:0];
  assign offset = addr - base;
  assign rel_w  = {1'b1, offset[TOP_ORDER-1:0]} >> rord;
  assign rel_idx = rel_w[IW-1:0];

  // walk index and node order
  always_ff @(posedge clk) begin
    case (cmd.idx_op)
      bba_pkg::IDX_ROOT: begin
        idx <= IW'(1);
        ord <= OW'(TOP_ORDER);
      end
      bba_pkg::IDX_LEFT: begin
        idx <= {idx[IW-2:0], 1'b0};
        ord <= ord - 1'b1;
      end
      bba_pkg::IDX_UP: begin
        idx <= idx >> 1;
        ord <= ord + 1'b1;
      end
      bba_pkg::IDX_NEXT: idx <= idx + 1'b1;
      bba_pkg::IDX_REL: begin
        idx <= rel_idx;
        ord <= rord;
      end
      default: ;
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.wr_en && cmd.wr_sel == bba_pkg::WA_CLR) clr_cnt <= clr_cnt + 1'b1;
  end

  always_comb begin
    wval = cmd.wr_val;
    case (cmd.wr_sel)
      bba_pkg::WA_IDX:   waddr = idx;
      bba_pkg::WA_BUDDY: waddr = idx ^ IW'(1);
      bba_pkg::WA_LEFT:  waddr = {idx[IW-2:0], 1'b0};
      bba_pkg::WA_RIGHT: waddr = {idx[IW-2:0], 1'b1};
      bba_pkg::WA_CLR: begin
        waddr = clr_cnt;
        wval  = (clr_cnt == IW'(1)) ? bba_pkg::NODE_FREE : bba_pkg::NODE_UNUSED;
      end
      default: waddr = idx;
    endcase
  end

  assign raddr = cmd.rd_buddy ? (idx ^ IW'(1)) : idx;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[waddr] <= wval;
    if (cmd.rd_en) rdata <= mem[raddr];
  end

  // status to controller
  always_comb begin
    sts.action     = action;
    sts.too_large  = k6 > {1'b0, max_order};
    sts.no_fit     = k6 > 6'(TOP_ORDER);
    sts.rel_bad    = (rord < OW'(MIN_ORDER)) || (rord > OW'(TOP_ORDER))
                  || (offset[AW-1:TOP_ORDER] != '0)
                  || ((offset & ~({AW{1'b1}} << rord)) != '0);
    sts.node       = bba_pkg::node_t'(rdata);
    sts.idx_root   = (idx == IW'(1));
    sts.idx_odd    = idx[0];
    sts.ord_eq_tgt = (ord == tgt);
    sts.clr_last   = &clr_cnt;
  end

  // result: position within the level scaled to bytes, top bit drops out
  assign pos_w     = (TOP_ORDER+1)'(idx) << ord;
  assign start_c   = base + AW'(pos_w[TOP_ORDER-1:0]);
  assign span_mask = ~({AW{1'b1}} << ord);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status <= cmd.res_code;
      if (cmd.res_code == bba_pkg::ST_GRANTED) begin
        out_data <= {3'b000, ord, start_c + span_mask, start_c};
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule

// File: hdl/buddy_block_allocator.sv
// buddy_block_allocator: top level of the binary buddy allocator
// depends on bba_pkg, bba_ctrl and bba_datapath
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-----------------------------------
//  s_*      | in        | s_tvalid/tready  | tuser action, tdata size/addr/order
//  m_*      | out       | m_tvalid/tready  | tuser status, tdata start/end/order
//  cfg_*    | in        | cfg_we           | cfg_addr register, cfg_data value
//
// one item at a time; an allocate reads tree nodes one by one, climbing and
// splitting level by level, a release frees the block and merges level by level,
// all through the single-port node state memory (one access per cycle)
// after reset a clearing pass over all 2^(TOP_ORDER-MIN_ORDER+1) node entries runs with
// s_tready low; configuration writes are taken throughout
// a finished result waits in the output register while m_tready is low
module buddy_block_allocator #(
  parameter int TOP_ORDER = bba_pkg::TOP_ORDER_DEF,
  parameter int MIN_ORDER = bba_pkg::MIN_ORDER_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic                          s_tuser,  // action
  input  logic [bba_pkg::DATA_W-1:0]    s_tdata,  // request_size, block_address, block_order
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bba_pkg::STAT_W-1:0]    m_tuser,  // status
  output logic [bba_pkg::DATA_W-1:0]    m_tdata,  // granted_start, granted_end, granted_order
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_data
);

  // controller to datapath commands and status back
  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_datapath #(
    .TOP_ORDER (TOP_ORDER),
    .MIN_ORDER (MIN_ORDER)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_action  (s_tuser),
    .in_data    (s_tdata),
    .out_status (m_tuser),
    .out_data   (m_tdata)
  );

endmodule

// File: test/tb_buddy_block_allocator.sv
// tb_buddy_block_allocator: self-checking testbench for the buddy block allocator
// depends on bba_pkg and buddy_block_allocator; predicts every result and compares
// in order, with random stalls on both stream sides and several register settings
module tb_buddy_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOP        = bba_pkg::TOP_ORDER_DEF;
  localparam int MINO       = bba_pkg::MIN_ORDER_DEF;
  localparam int SLOTS      = 1 << (TOP - MINO + 1);
  localparam int STALL_LIM  = 400000;  // covers the clearing pass and a full tree walk
  localparam int HOLD_LEN   = 3000;

  typedef struct {
    logic        action;
    logic [31:0] size;
    logic [31:0] addr;
    logic [4:0]  ord;
  } req_t;

  typedef struct {
    bba_pkg::status_t status;
    logic [31:0]      first_addr;
    logic [31:0]      last_addr;
    logic [4:0]       ord;
  } grant_t;

  typedef struct {
    logic [31:0] offset;
    logic [4:0]  ord;
  } live_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic s_tuser = 1'b0;
  logic [bba_pkg::DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [bba_pkg::STAT_W-1:0] m_tuser;
  logic [bba_pkg::DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_addr = bba_pkg::REG_BASE;
  logic [bba_pkg::CFG_W-1:0] cfg_data = '0;

  buddy_block_allocator uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow allocator state
  bba_pkg::node_t tree [1:SLOTS-1];
  logic [31:0]    region_base;
  logic [4:0]     order_limit;

  req_t   pending_reqs[$];
  grant_t grant_q[$];
  live_t  live_blocks[$];
  req_t   in_flight;
  int     errors = 0;
  int     send_idle = 0;
  int     recv_idle = 0;
  logic   hold_req = 1'b0;
  logic   hold_done = 1'b0;
  int     hold_cnt = 0;

  function automatic void tree_reset();
    for (int i = 1; i < SLOTS; i++) tree[i] = bba_pkg::NODE_UNUSED;
    tree[1] = bba_pkg::NODE_FREE;
  endfunction

  // lowest-addressed free block of order >= k, preorder walk from the root
  function automatic int find_free(int k, output int ford);
    int idx;
    int ord;
    idx = 1;
    ord = TOP;
    ford = 0;
    while (1) begin
      if (tree[idx] == bba_pkg::NODE_FREE) begin
        ford = ord;
        return idx;
      end
      if (tree[idx] == bba_pkg::NODE_SPLIT && ord > k) begin
        idx = 2 * idx;
        ord--;
      end else begin
        while (idx > 1 && (idx % 2) == 1) begin
          idx = idx / 2;
          ord++;
        end
        if (idx == 1) return 0;
        idx++;
      end
    end
  endfunction

  function automatic grant_t allocate(logic [31:0] size);
    grant_t g;
    int k;
    int idx;
    int ford;
    int lv;
    logic [31:0] pos;
    g = '{bba_pkg::ST_GRANTED, 32'd0, 32'd0, 5'd0};
    k = 1;
    while (k < 32 && (64'd1 << k) < {32'd0, size}) k++;
    if (k > order_limit) begin
      g.status = bba_pkg::ST_TOO_LARGE;
      return g;
    end
    if (k < MINO) k = MINO;
    if (k > TOP) begin
      g.status = bba_pkg::ST_NO_FREE;
      return g;
    end
    idx = find_free(k, ford);
    if (idx == 0) begin
      g.status = bba_pkg::ST_NO_FREE;
      return g;
    end
    // split down the low half until the order fits
    while (ford > k) begin
      tree[idx] = bba_pkg::NODE_SPLIT;
      tree[2*idx] = bba_pkg::NODE_FREE;
      tree[2*idx+1] = bba_pkg::NODE_FREE;
      idx = 2 * idx;
      ford--;
    end
    tree[idx] = bba_pkg::NODE_ALLOC;
    lv = TOP - k;
    pos = 32'(idx - (1 << lv)) << k;
    g.first_addr = region_base + pos;
    g.last_addr = g.first_addr + ((32'd1 << k) - 32'd1);
    g.ord = 5'(k);
    live_blocks.push_back('{pos, 5'(k)});
    return g;
  endfunction

  function automatic grant_t release_block(logic [31:0] addr, logic [4:0] ord);
    grant_t g;
    logic [31:0] offset;
    int idx;
    g = '{bba_pkg::ST_BAD_RELEASE, 32'd0, 32'd0, 5'd0};
    if (ord < MINO || ord > TOP) return g;
    offset = addr - region_base;
    if (offset >= (32'd1 << TOP) || (offset & ((32'd1 << ord) - 32'd1)) != 0) return g;
    idx = (1 << (TOP - ord)) + int'(offset >> ord);
    if (tree[idx] != bba_pkg::NODE_ALLOC) return g;
    tree[idx] = bba_pkg::NODE_FREE;
    // merge upward while the buddy is free too
    while (idx > 1 && tree[idx ^ 1] == bba_pkg::NODE_FREE) begin
      tree[idx] = bba_pkg::NODE_UNUSED;
      tree[idx ^ 1] = bba_pkg::NODE_UNUSED;
      idx = idx / 2;
      tree[idx] = bba_pkg::NODE_FREE;
    end
    g.status = bba_pkg::ST_RELEASED;
    return g;
  endfunction

  // driver: one transfer in flight, refilled from the pending queue
  always @(posedge clk) begin
    if (!rst && (!s_tvalid || s_tready)) begin
      if (s_tvalid) begin
        if (in_flight.action) grant_q.push_back(release_block(in_flight.addr, in_flight.ord));
        else grant_q.push_back(allocate(in_flight.size));
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_flight = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= in_flight.action;
        s_tdata <= {3'd0, in_flight.ord, in_flight.addr, in_flight.size};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    grant_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result transfer, status %0d", m_tuser);
          errors++;
        end else begin
          want = grant_q.pop_front();
          if (m_tuser != want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            errors++;
          end
          if (m_tdata[31:0] != want.first_addr) begin
            $error("granted_start: expected %h, got %h", want.first_addr, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[63:32] != want.last_addr) begin
            $error("granted_end: expected %h, got %h", want.last_addr, m_tdata[63:32]);
            errors++;
          end
          if (m_tdata[68:64] != want.ord) begin
            $error("granted_order: expected %0d, got %0d", want.ord, m_tdata[68:64]);
            errors++;
          end
        end
      end
      // long hold-off so the block backs up into its input
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_LEN) hold_done <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIM) begin
      $display("tb_buddy_block_allocator: errors");
      $finish;
    end
  end

  task automatic push_alloc(logic [31:0] size);
    pending_reqs.push_back('{1'b0, size, $urandom, 5'($urandom)});
  endtask

  task automatic push_release(logic [31:0] addr, logic [4:0] ord);
    pending_reqs.push_back('{1'b1, $urandom, addr, ord});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() > 0 || s_tvalid || grant_q.size() > 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bba_pkg::REG_BASE) region_base = val;
    else order_limit = val[4:0];
    @(negedge clk);
  endtask

  task automatic push_random();
    int r;
    int pick;
    live_t b;
    r = $urandom_range(99);
    if (r < 8) begin
      // malformed release: wild address, unaligned offset or odd order
      if (r < 4) push_release($urandom, 5'($urandom));
      else push_release(region_base + $urandom_range(0, 1 << (TOP + 1)),
                        5'($urandom_range(MINO - 1, TOP + 1)));
    end else if (r < 12) begin
      push_alloc($urandom);
    end else if (live_blocks.size() > 0 && r < (live_blocks.size() > 48 ? 70 : 45)) begin
      pick = $urandom_range(0, live_blocks.size() - 1);
      b = live_blocks[pick];
      live_blocks.delete(pick);
      push_release(region_base + b.offset, b.ord);
    end else if (r < 90) begin
      push_alloc($urandom_range(0, 1 << $urandom_range(0, 10)));
    end else begin
      push_alloc($urandom_range(0, 1 << $urandom_range(11, TOP + 1)));
    end
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      while (pending_reqs.size() > 6) @(negedge clk);
      push_random();
    end
  endtask

  logic [31:0] base_sel [9] = '{32'hFFF8_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                                32'hFFF8_0000, 32'h0, 32'h0, 32'h0001_0000};
  logic [4:0]  limit_sel [9] = '{5'd19, 5'd5, 5'd12, 5'd8, 5'd19, 5'd16, 5'd10, 5'd5, 5'd19};

  initial begin
    tree_reset();
    region_base = bba_pkg::BASE_RESET;
    order_limit = bba_pkg::MAX_ORDER_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings, size corners, every kind of bad release
    send_idle = 16;
    recv_idle = 58;
    push_alloc(32'd0);
    push_alloc(32'd33);
    push_alloc(32'd1);
    push_alloc(32'd2);
    push_release(32'h0001_0000, 5'd5);
    push_release(32'h0001_0000, 5'd5);       // already free
    push_release(32'h0001_0008, 5'd5);       // unaligned
    push_release(32'h0000_0000, 5'd5);       // below the region
    push_release(32'h0009_0000, 5'd5);       // past the region
    push_release(32'h0001_0000, 5'd4);       // order too small
    push_release(32'h0001_0000, 5'd20);      // order too big
    push_release(32'hFFFF_FFFF, 5'd31);
    push_alloc(32'h0001_0000);
    push_alloc(32'h0001_0001);                // over max_order
    push_alloc(32'h8000_0000);
    push_alloc(32'h8000_0001);                // rounds to order 32
    push_alloc(32'hFFFF_FFFF);
    write_reg(bba_pkg::REG_MAX_ORDER, 32'd19);
    push_alloc(32'h0008_0000);                // region partly used
    wait_idle();
    while (live_blocks.size() > 0) begin
      push_release(region_base + live_blocks[0].offset, live_blocks[0].ord);
      void'(live_blocks.pop_front());
    end
    push_alloc(32'h0008_0000);                // whole region after merging
    push_release(32'h0001_0000, 5'd19);
    wait_idle();
    live_blocks.delete();

    for (int p = 0; p < 9; p++) begin
      write_reg(bba_pkg::REG_BASE, base_sel[p] != 0 || p == 2 || p == 7 ? base_sel[p]
                : $urandom_range(0, 32'hFFF8_0000));
      write_reg(bba_pkg::REG_MAX_ORDER, {27'd0, limit_sel[p]});
      if (p < 3) begin
        send_idle = 16;
        recv_idle = 58;
      end else if (p < 6) begin
        send_idle = 58;
        recv_idle = 16;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 1) hold_req = 1'b1;
      run_random(75);
      if (p == 4) wait_idle();               // sender pause until all results are in
      run_random(75);
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_buddy_block_allocator: clean");
    end else begin
      $display("tb_buddy_block_allocator: errors");
    end
    $finish;
  end

endmodule
